[hw/rtl/vrcs_pkg.sv]
// Shared types, codes and helpers of the ring-crossing sequencer.
package vrcs_pkg;

  localparam int unsigned CFG_INDEX_W = 4;

  // Item kinds.
  localparam logic OP_DETECT = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // Command codes of a result.
  localparam logic [1:0] CMD_HOVER = 2'd0;
  localparam logic [1:0] CMD_MOVE  = 2'd1;
  localparam logic [1:0] CMD_LAND  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN       = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CROSS_LIM  = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CROSS_SPD  = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CAM_OFFSET = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_STANDOFF   = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_CROSS_DIST = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_QUAL_LIMIT = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SCORE_THR  = 4'd7;

  // Register values after reset.
  localparam logic [47:0] RST_GAIN       = 48'd14074822592102;
  localparam logic [47:0] RST_CROSS_LIM  = 48'd163211247729;
  localparam logic [47:0] RST_CROSS_SPD  = 48'd77;
  localparam logic [47:0] RST_CAM_OFFSET = 48'd281311767953408;
  localparam logic [14:0] RST_STANDOFF   = 15'd95;
  localparam logic [14:0] RST_CROSS_DIST = 15'd512;
  localparam logic [7:0]  RST_QUAL_LIMIT = 8'd10;
  localparam logic [7:0]  RST_SCORE_THR  = 8'd230;

  typedef struct packed {
    logic [47:0] gain_xyz;
    logic [47:0] cross_limits_xyz;
    logic [47:0] cross_speed_xyz;
    logic [47:0] camera_offset_xyz;
    logic [14:0] standoff_distance;
    logic [14:0] crossing_distance;
    logic [7:0]  qualify_limit;
    logic [7:0]  score_threshold;
  } cfg_t;

  typedef struct packed {
    logic               opcode;
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic signed [15:0] target_z;
    logic [7:0]         confidence;
    logic               command_mode;
    logic signed [31:0] position_east;
  } item_t;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_z;
    logic [31:0]        cmd_serial;
    logic [1:0]         phase;
  } result_t;

  // Clamp a signed value to the signed 16-bit range.
  function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
    logic signed [15:0] r;
    if (v > 24'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -24'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

[hw/rtl/vrcs_cfg_regs.sv]
// Configuration register file of the ring-crossing sequencer.
module vrcs_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [vrcs_pkg::CFG_INDEX_W-1:0]   wr_index,
  input  logic [47:0]                        wr_data,
  output vrcs_pkg::cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_xyz          <= vrcs_pkg::RST_GAIN;
      cfg.cross_limits_xyz  <= vrcs_pkg::RST_CROSS_LIM;
      cfg.cross_speed_xyz   <= vrcs_pkg::RST_CROSS_SPD;
      cfg.camera_offset_xyz <= vrcs_pkg::RST_CAM_OFFSET;
      cfg.standoff_distance <= vrcs_pkg::RST_STANDOFF;
      cfg.crossing_distance <= vrcs_pkg::RST_CROSS_DIST;
      cfg.qualify_limit     <= vrcs_pkg::RST_QUAL_LIMIT;
      cfg.score_threshold   <= vrcs_pkg::RST_SCORE_THR;
    end else if (wr_en) begin
      unique case (wr_index)
        vrcs_pkg::REG_GAIN:       cfg.gain_xyz          <= wr_data;
        vrcs_pkg::REG_CROSS_LIM:  cfg.cross_limits_xyz  <= wr_data;
        vrcs_pkg::REG_CROSS_SPD:  cfg.cross_speed_xyz   <= wr_data;
        vrcs_pkg::REG_CAM_OFFSET: cfg.camera_offset_xyz <= wr_data;
        vrcs_pkg::REG_STANDOFF:   cfg.standoff_distance <= wr_data[14:0];
        vrcs_pkg::REG_CROSS_DIST: cfg.crossing_distance <= wr_data[14:0];
        vrcs_pkg::REG_QUAL_LIMIT: cfg.qualify_limit     <= wr_data[7:0];
        vrcs_pkg::REG_SCORE_THR:  cfg.score_threshold   <= wr_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

[hw/rtl/vrcs_gain_mul.sv]
// Q4.12 gain times signed Q8.8 value, rounded half up and clamped to 16 bits.
module vrcs_gain_mul (
  input  logic [15:0]        gain,
  input  logic signed [16:0] val,
  output logic signed [15:0] prod_sat
);

  logic signed [33:0] prod;
  logic signed [34:0] rounded;
  logic signed [22:0] scaled;

  assign prod     = $signed({1'b0, gain}) * val;
  assign rounded  = {prod[33], prod} + 35'sd2048;
  assign scaled   = rounded[34:12];
  assign prod_sat = vrcs_pkg::sat16({scaled[22], scaled});

endmodule

[hw/rtl/vrcs_seq.sv]
// Detection qualification, mission sequencer and all of its state.
module vrcs_seq (
  input  logic              clk,
  input  logic              rst,
  input  vrcs_pkg::cfg_t    cfg,
  input  vrcs_pkg::item_t   item,
  input  logic              fire,
  output logic              emit,
  output vrcs_pkg::result_t res
);

  typedef enum logic [1:0] {
    PHASE_WAIT,
    PHASE_TRACK,
    PHASE_CROSS
  } phase_t;

  phase_t             phase, phase_next;
  logic [7:0]         lost_count, regain_count;
  logic [7:0]         lost_next, regain_next;
  logic               detected_flag, detected_next;
  logic signed [15:0] raw_x, raw_y, raw_z;
  logic signed [15:0] body_f, body_l, body_u;
  logic signed [15:0] body_f_next, body_l_next, body_u_next;
  logic signed [31:0] start_east, start_east_next;
  logic [1:0]         last_command, last_command_next;
  logic signed [15:0] vel_x, vel_y, vel_z;
  logic signed [15:0] vel_x_next, vel_y_next, vel_z_next;
  logic [31:0]        sequence_count, sequence_count_next;

  logic               conf_good;
  logic signed [15:0] off_x, off_y, off_z;
  logic signed [17:0] sum_f, sum_l, sum_u;
  logic signed [16:0] track_x, track_y, track_z;
  logic signed [15:0] mul_x, mul_y, mul_z;
  logic               cross_ok, land_ok;
  logic signed [33:0] land_mark;

  assign emit = (item.opcode == vrcs_pkg::OP_TICK) && item.command_mode;

  // Camera frame to body frame: forward is z, left is -x, up is -y.
  assign off_x = $signed(cfg.camera_offset_xyz[15:0]);
  assign off_y = $signed(cfg.camera_offset_xyz[31:16]);
  assign off_z = $signed(cfg.camera_offset_xyz[47:32]);
  assign sum_f = {{2{item.target_z[15]}}, item.target_z} + {{2{off_x[15]}}, off_x};
  assign sum_l = {{2{off_y[15]}}, off_y} - {{2{item.target_x[15]}}, item.target_x};
  assign sum_u = {{2{off_z[15]}}, off_z} - {{2{item.target_y[15]}}, item.target_y};
  assign body_f_next = vrcs_pkg::sat16({{6{sum_f[17]}}, sum_f});
  assign body_l_next = vrcs_pkg::sat16({{6{sum_l[17]}}, sum_l});
  assign body_u_next = vrcs_pkg::sat16({{6{sum_u[17]}}, sum_u});

  // Run counts: a good report extends the good run and ends the bad one.
  assign conf_good = item.confidence >= cfg.score_threshold;
  always_comb begin
    if (conf_good) begin
      regain_next = (regain_count == 8'hFF) ? regain_count : regain_count + 8'd1;
      lost_next   = 8'd0;
    end else begin
      regain_next = 8'd0;
      lost_next   = (lost_count == 8'hFF) ? lost_count : lost_count + 8'd1;
    end
    if (regain_next > cfg.qualify_limit) begin
      detected_next = 1'b1;
    end else if (lost_next > cfg.qualify_limit) begin
      detected_next = 1'b0;
    end else begin
      detected_next = detected_flag;
    end
  end

  // Tracking terms use the stored body-frame target.
  assign track_x = {body_f[15], body_f} - {2'b00, cfg.standoff_distance};
  assign track_y = {body_l[15], body_l};
  assign track_z = {body_u[15], body_u};

  vrcs_gain_mul u_mul_x (.gain(cfg.gain_xyz[15:0]),  .val(track_x), .prod_sat(mul_x));
  vrcs_gain_mul u_mul_y (.gain(cfg.gain_xyz[31:16]), .val(track_y), .prod_sat(mul_y));
  vrcs_gain_mul u_mul_z (.gain(cfg.gain_xyz[47:32]), .val(track_z), .prod_sat(mul_z));

  assign cross_ok = (raw_z <= $signed(cfg.cross_limits_xyz[15:0])) &&
                    (raw_x <= $signed(cfg.cross_limits_xyz[31:16])) &&
                    (raw_y <= $signed(cfg.cross_limits_xyz[47:32]));
  assign land_mark = {{2{start_east[31]}}, start_east} + {19'd0, cfg.crossing_distance};
  assign land_ok   = $signed({{2{item.position_east[31]}}, item.position_east}) > land_mark;

  always_comb begin
    phase_next        = phase;
    last_command_next = last_command;
    vel_x_next        = vel_x;
    vel_y_next        = vel_y;
    vel_z_next        = vel_z;
    start_east_next   = start_east;
    unique case (phase)
      PHASE_WAIT: begin
        if (detected_flag) begin
          phase_next = PHASE_TRACK;
        end else begin
          last_command_next = vrcs_pkg::CMD_HOVER;
        end
      end
      PHASE_TRACK: begin
        last_command_next = vrcs_pkg::CMD_MOVE;
        vel_x_next        = mul_x;
        vel_y_next        = mul_y;
        vel_z_next        = mul_z;
        if (cross_ok) begin
          start_east_next = item.position_east;
          phase_next      = PHASE_CROSS;
        end
      end
      default: begin
        last_command_next = land_ok ? vrcs_pkg::CMD_LAND : vrcs_pkg::CMD_MOVE;
        vel_x_next        = $signed(cfg.cross_speed_xyz[15:0]);
        vel_y_next        = $signed(cfg.cross_speed_xyz[31:16]);
        vel_z_next        = $signed(cfg.cross_speed_xyz[47:32]);
      end
    endcase
  end

  assign sequence_count_next = sequence_count + 32'd1;

  assign res.command    = last_command_next;
  assign res.vel_x      = vel_x_next;
  assign res.vel_y      = vel_y_next;
  assign res.vel_z      = vel_z_next;
  assign res.cmd_serial = sequence_count_next;
  assign res.phase      = phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PHASE_WAIT;
      lost_count     <= 8'd0;
      regain_count   <= 8'd0;
      detected_flag  <= 1'b0;
      raw_x          <= 16'sd0;
      raw_y          <= 16'sd0;
      raw_z          <= 16'sd0;
      body_f         <= 16'sd0;
      body_l         <= 16'sd0;
      body_u         <= 16'sd0;
      start_east     <= 32'sd0;
      last_command   <= vrcs_pkg::CMD_HOVER;
      vel_x          <= 16'sd0;
      vel_y          <= 16'sd0;
      vel_z          <= 16'sd0;
      sequence_count <= 32'd1;
    end else if (fire) begin
      if (item.opcode == vrcs_pkg::OP_DETECT) begin
        raw_x         <= item.target_x;
        raw_y         <= item.target_y;
        raw_z         <= item.target_z;
        body_f        <= body_f_next;
        body_l        <= body_l_next;
        body_u        <= body_u_next;
        lost_count    <= lost_next;
        regain_count  <= regain_next;
        detected_flag <= detected_next;
      end else if (!item.command_mode) begin
        regain_count <= 8'd0;
      end else begin
        phase          <= phase_next;
        last_command   <= last_command_next;
        vel_x          <= vel_x_next;
        vel_y          <= vel_y_next;
        vel_z          <= vel_z_next;
        start_east     <= start_east_next;
        sequence_count <= sequence_count_next;
      end
    end
  end

  // One run count is always zero.
  assert property (@(posedge clk) disable iff (rst)
    !((lost_count != 8'd0) && (regain_count != 8'd0)))
    else $error("lost and regain counts both nonzero");

  // The detected flag can only be set by a detection beat.
  assert property (@(posedge clk) disable iff (rst)
    $rose(detected_flag) |-> $past(fire && (item.opcode == vrcs_pkg::OP_DETECT)))
    else $error("detected flag set without a detection");

endmodule

[hw/rtl/visual_ring_crossing_sequencer_unit.sv]
// Top level of the ring-crossing sequencer: input register, output register, handshakes.
// Each accepted beat is a detection report or a control tick. The block takes one beat
// per clock cycle when the result side is not stalled: a beat is held in the input
// register, its whole update (body-frame offset, run counts, three gain multiplies,
// phase step) is done while it is held there, and a command result is written to the
// output register as the beat leaves the input register. Detections and ticks
// outside command mode produce no result and pass through even while a result waits
// to be taken.
// Configuration writes are always ready and take effect in the following cycle.
module visual_ring_crossing_sequencer_unit (
  input  logic               clk,
  input  logic               rst,
  // Item channel.
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               opcode,
  input  logic signed [15:0] target_x,
  input  logic signed [15:0] target_y,
  input  logic signed [15:0] target_z,
  input  logic [7:0]         confidence,
  input  logic               command_mode,
  input  logic signed [31:0] position_east,
  // Result channel.
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         command,
  output logic signed [15:0] vel_x,
  output logic signed [15:0] vel_y,
  output logic signed [15:0] vel_z,
  output logic [31:0]        cmd_serial,
  output logic [1:0]         phase,
  // Configuration channel.
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [vrcs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [47:0]        cfg_data
);

  vrcs_pkg::cfg_t    cfg;
  vrcs_pkg::item_t   item_q;
  vrcs_pkg::result_t res;
  logic              in_full;
  logic              in_fire;
  logic              emit;
  logic              out_free;
  logic              advance;
  logic              emit_fire;

  assign cfg_ready = 1'b1;

  vrcs_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // A beat leaves the input register unless it needs the output register and that is busy.
  assign out_free  = !out_valid || !out_stall;
  assign advance   = in_full && (!emit || out_free);
  assign emit_fire = advance && emit;
  assign in_stall  = in_full && !advance;
  assign in_fire   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_fire) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_q.opcode        <= opcode;
      item_q.target_x      <= target_x;
      item_q.target_y      <= target_y;
      item_q.target_z      <= target_z;
      item_q.confidence    <= confidence;
      item_q.command_mode  <= command_mode;
      item_q.position_east <= position_east;
    end
  end

  vrcs_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .item (item_q),
    .fire (advance),
    .emit (emit),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      command    <= res.command;
      vel_x      <= res.vel_x;
      vel_y      <= res.vel_y;
      vel_z      <= res.vel_z;
      cmd_serial <= res.cmd_serial;
      phase      <= res.phase;
    end
  end

  // A new result never overwrites one that is still stalled.
  assert property (@(posedge clk) disable iff (rst)
    !(emit_fire && out_valid && out_stall))
    else $error("result overwritten while stalled");

  // Stall is raised only while a beat is held.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_full)
    else $error("input stalled with empty input register");

endmodule
